// ===== hw/rtl/sgbu_pkg.sv =====
// shared constants, result codes and control types for the spatial grid bucket updater
package sgbu_pkg;

  // fixed field widths
  localparam int ObjIdW   = 10;
  localparam int CellW    = 12;
  localparam int StatusW  = 2;
  localparam int NewFillW = 4;

  // default sizing
  localparam int MAX_OBJECTS_DEF   = 1024;
  localparam int NUM_CELLS_DEF     = 4096;
  localparam int CELL_CAPACITY_DEF = 8;

  // result status codes
  localparam logic [StatusW-1:0] STAT_SAME    = 2'd0;
  localparam logic [StatusW-1:0] STAT_INSERT  = 2'd1;
  localparam logic [StatusW-1:0] STAT_DROPPED = 2'd2;

  // write strobes from the sequencer to the tables
  typedef struct packed {
    logic lc_we;
    logic fill_we;
    logic slot_we;
  } tbl_ctl_t;

endpackage

// ===== hw/rtl/sgbu_if.sv =====
// valid/ready channel interfaces for request and response words
interface sgbu_req_if;
  logic                         valid;
  logic                         ready;
  logic [sgbu_pkg::ObjIdW-1:0]  object_id;
  logic [sgbu_pkg::CellW-1:0]   target_cell;

  modport source (output valid, output object_id, output target_cell, input ready);
  modport sink   (input valid, input object_id, input target_cell, output ready);
endinterface

interface sgbu_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [sgbu_pkg::StatusW-1:0]  status;
  logic                          found_in_old;
  logic [sgbu_pkg::NewFillW-1:0] new_fill;

  modport source (output valid, output status, output found_in_old, output new_fill,
                  input ready);
  modport sink   (input valid, input status, input found_in_old, input new_fill,
                  output ready);
endinterface

// ===== hw/rtl/sgbu_tables.sv =====
// last-cell, fill-count and bucket-slot memories with post-reset clearing sweep
module sgbu_tables #(
  parameter int MAX_OBJECTS   = sgbu_pkg::MAX_OBJECTS_DEF,
  parameter int NUM_CELLS     = sgbu_pkg::NUM_CELLS_DEF,
  parameter int CELL_CAPACITY = sgbu_pkg::CELL_CAPACITY_DEF,
  localparam int LcAw      = $clog2(MAX_OBJECTS),
  localparam int FcAw      = $clog2(NUM_CELLS),
  localparam int SlotDepth = NUM_CELLS * CELL_CAPACITY,
  localparam int SlAw      = $clog2(SlotDepth),
  localparam int FillW     = $clog2(CELL_CAPACITY + 1)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  sgbu_pkg::tbl_ctl_t           ctl,
  input  logic [LcAw-1:0]              lc_waddr,
  input  logic [sgbu_pkg::CellW-1:0]   lc_wdata,
  input  logic [LcAw-1:0]              lc_raddr,
  output logic [sgbu_pkg::CellW-1:0]   lc_rdata,
  input  logic [FcAw-1:0]              fill_waddr,
  input  logic [FillW-1:0]             fill_wdata,
  input  logic [FcAw-1:0]              fill_raddr,
  output logic [FillW-1:0]             fill_rdata,
  input  logic [SlAw-1:0]              slot_waddr,
  input  logic [sgbu_pkg::ObjIdW-1:0]  slot_wdata,
  input  logic [SlAw-1:0]              slot_raddr,
  output logic [sgbu_pkg::ObjIdW-1:0]  slot_rdata,
  output logic                         clear_done
);

  localparam int ClrDepth = (MAX_OBJECTS > NUM_CELLS) ? MAX_OBJECTS : NUM_CELLS;
  localparam int ClrW     = $clog2(ClrDepth);

  logic [sgbu_pkg::CellW-1:0]  lc_mem   [MAX_OBJECTS];
  logic [FillW-1:0]            fill_mem [NUM_CELLS];
  logic [sgbu_pkg::ObjIdW-1:0] slot_mem [SlotDepth];

  logic [ClrW-1:0]            clr_cnt;
  logic                       lc_we_eff;
  logic [LcAw-1:0]            lc_wa_eff;
  logic [sgbu_pkg::CellW-1:0] lc_wd_eff;
  logic                       fill_we_eff;
  logic [FcAw-1:0]            fill_wa_eff;
  logic [FillW-1:0]           fill_wd_eff;

  // clearing sweep, one entry of the last-cell and fill tables per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt    <= '0;
      clear_done <= 1'b0;
    end else if (!clear_done) begin
      if (clr_cnt == ClrW'(ClrDepth - 1)) begin
        clear_done <= 1'b1;
      end else begin
        clr_cnt <= clr_cnt + ClrW'(1);
      end
    end
  end

  always_comb begin
    if (!clear_done) begin
      lc_we_eff   = {1'b0, clr_cnt} < (ClrW + 1)'(MAX_OBJECTS);
      lc_wa_eff   = clr_cnt[LcAw-1:0];
      lc_wd_eff   = '0;
      fill_we_eff = {1'b0, clr_cnt} < (ClrW + 1)'(NUM_CELLS);
      fill_wa_eff = clr_cnt[FcAw-1:0];
      fill_wd_eff = '0;
    end else begin
      lc_we_eff   = ctl.lc_we;
      lc_wa_eff   = lc_waddr;
      lc_wd_eff   = lc_wdata;
      fill_we_eff = ctl.fill_we;
      fill_wa_eff = fill_waddr;
      fill_wd_eff = fill_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (lc_we_eff) begin
      lc_mem[lc_wa_eff] <= lc_wd_eff;
    end
    lc_rdata <= lc_mem[lc_raddr];
  end

  always_ff @(posedge clk) begin
    if (fill_we_eff) begin
      fill_mem[fill_wa_eff] <= fill_wd_eff;
    end
    fill_rdata <= fill_mem[fill_raddr];
  end

  // slots need no clearing: only entries below a bucket's fill are read
  always_ff @(posedge clk) begin
    if (ctl.slot_we && clear_done) begin
      slot_mem[slot_waddr] <= slot_wdata;
    end
    slot_rdata <= slot_mem[slot_raddr];
  end

endmodule

// ===== hw/rtl/spatial_grid_bucket_update_top.sv =====
// spatial grid bucket updater: sequencer, shared index multiplier and response register
// one word at a time: an unchanged cell goes from lookup to the response, an out-of-range word
//   straight to it, and a move searches the old bucket slot by slot, removes on a hit and inserts;
//   a new word is taken only after the result is handed to the response register
// reset: synchronous; a sweep zeroes last cells and fill counts while ready stays low
module spatial_grid_bucket_update_top #(
  parameter int MAX_OBJECTS   = sgbu_pkg::MAX_OBJECTS_DEF,
  parameter int NUM_CELLS     = sgbu_pkg::NUM_CELLS_DEF,
  parameter int CELL_CAPACITY = sgbu_pkg::CELL_CAPACITY_DEF
) (
  input logic        clk,
  input logic        rst,
  sgbu_req_if.sink   req,
  sgbu_rsp_if.source rsp
);

  localparam int LcAw      = $clog2(MAX_OBJECTS);
  localparam int FcAw      = $clog2(NUM_CELLS);
  localparam int SlotDepth = NUM_CELLS * CELL_CAPACITY;
  localparam int SlAw      = $clog2(SlotDepth);
  localparam int FillW     = $clog2(CELL_CAPACITY + 1);
  localparam int IdxW      = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE     = 3'd0;  // waiting for a request word
  localparam logic [2:0] ST_LOOKUP   = 3'd1;  // last cell and new fill come back
  localparam logic [2:0] ST_OLD_FILL = 3'd2;  // old bucket fill comes back
  localparam logic [2:0] ST_SEARCH   = 3'd3;  // one old-bucket slot compared per cycle
  localparam logic [2:0] ST_MOVE     = 3'd4;  // last entry moves into the hole
  localparam logic [2:0] ST_INSERT   = 3'd5;  // append to new bucket, record new cell
  localparam logic [2:0] ST_FIN      = 3'd6;  // hand result to response register

  logic [2:0]                    state;
  logic [sgbu_pkg::ObjIdW-1:0]   obj;
  logic [sgbu_pkg::CellW-1:0]    nc;
  logic [sgbu_pkg::CellW-1:0]    oc;
  logic [FillW-1:0]              nf;
  logic [FillW-1:0]              n;
  logic [IdxW-1:0]               idx;
  logic [SlAw-1:0]               base_old;
  logic [SlAw-1:0]               base_new;
  logic [sgbu_pkg::StatusW-1:0]  res_status;
  logic                          res_found;
  logic [FillW-1:0]              res_fill;
  logic                          out_valid;
  logic [sgbu_pkg::StatusW-1:0]  out_status;
  logic                          out_found;
  logic [sgbu_pkg::NewFillW-1:0] out_fill;

  // table port signals
  sgbu_pkg::tbl_ctl_t          ctl;
  logic [LcAw-1:0]             lc_waddr;
  logic [sgbu_pkg::CellW-1:0]  lc_wdata;
  logic [LcAw-1:0]             lc_raddr;
  logic [sgbu_pkg::CellW-1:0]  lc_rdata;
  logic [FcAw-1:0]             fill_waddr;
  logic [FillW-1:0]            fill_wdata;
  logic [FcAw-1:0]             fill_raddr;
  logic [FillW-1:0]            fill_rdata;
  logic [SlAw-1:0]             slot_waddr;
  logic [sgbu_pkg::ObjIdW-1:0] slot_wdata;
  logic [SlAw-1:0]             slot_raddr;
  logic [sgbu_pkg::ObjIdW-1:0] slot_rdata;
  logic                        clear_done;

  logic                        accept;
  logic                        in_range;
  logic [sgbu_pkg::CellW-1:0]  mul_a;
  logic [SlAw-1:0]             mul_p;
  logic [FillW-1:0]            fill_clamped;
  logic [FillW-1:0]            idx_inc;
  logic                        hit;
  logic                        room;
  logic                        fin_load;

  sgbu_tables #(
    .MAX_OBJECTS   (MAX_OBJECTS),
    .NUM_CELLS     (NUM_CELLS),
    .CELL_CAPACITY (CELL_CAPACITY)
  ) u_tables (
    .clk        (clk),
    .rst        (rst),
    .ctl        (ctl),
    .lc_waddr   (lc_waddr),
    .lc_wdata   (lc_wdata),
    .lc_raddr   (lc_raddr),
    .lc_rdata   (lc_rdata),
    .fill_waddr (fill_waddr),
    .fill_wdata (fill_wdata),
    .fill_raddr (fill_raddr),
    .fill_rdata (fill_rdata),
    .slot_waddr (slot_waddr),
    .slot_wdata (slot_wdata),
    .slot_raddr (slot_raddr),
    .slot_rdata (slot_rdata),
    .clear_done (clear_done)
  );

  // request side: one word in flight, held off during the clearing sweep
  assign req.ready = (state == ST_IDLE) && clear_done;
  assign accept    = req.valid && req.ready;
  assign in_range  = (32'(req.object_id) < 32'(MAX_OBJECTS))
                  && (32'(req.target_cell) < 32'(NUM_CELLS));

  // shared bucket base multiplier: old cell in lookup, new cell after
  assign mul_a = (state == ST_LOOKUP) ? lc_rdata : nc;
  assign mul_p = SlAw'(32'(mul_a) * 32'(CELL_CAPACITY));

  assign fill_clamped = (fill_rdata > FillW'(CELL_CAPACITY)) ? FillW'(CELL_CAPACITY)
                                                             : fill_rdata;
  assign idx_inc = FillW'(idx) + FillW'(1);
  assign hit     = (slot_rdata == obj);
  assign room    = nf < FillW'(CELL_CAPACITY);

  // read addresses
  assign lc_raddr   = LcAw'(req.object_id);
  assign fill_raddr = (state == ST_LOOKUP) ? FcAw'(lc_rdata) : FcAw'(req.target_cell);

  always_comb begin
    slot_raddr = base_old;
    case (state)
      ST_SEARCH: begin
        // on a hit fetch the bucket's last entry, else the next slot
        if (hit) begin
          slot_raddr = base_old + SlAw'(n - FillW'(1));
        end else begin
          slot_raddr = base_old + SlAw'(idx_inc);
        end
      end
      default: begin
        slot_raddr = base_old;
      end
    endcase
  end

  // writes: removal in the move step, append and new last cell in the insert step
  always_comb begin
    ctl.lc_we   = (state == ST_INSERT);
    ctl.fill_we = (state == ST_MOVE) || ((state == ST_INSERT) && room);
    ctl.slot_we = (state == ST_MOVE) || ((state == ST_INSERT) && room);
    lc_waddr    = LcAw'(obj);
    lc_wdata    = nc;
    if (state == ST_MOVE) begin
      fill_waddr = FcAw'(oc);
      fill_wdata = n - FillW'(1);
      slot_waddr = base_old + SlAw'(idx);
      slot_wdata = slot_rdata;
    end else begin
      fill_waddr = FcAw'(nc);
      fill_wdata = nf + FillW'(1);
      slot_waddr = base_new + SlAw'(nf);
      slot_wdata = obj;
    end
  end

  // result goes to the response register unless an older word still sits unread
  assign fin_load = (state == ST_FIN) && (!out_valid || rsp.ready);

  // response valid: set on hand-over, cleared once the word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and response payload
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (accept) begin
            obj        <= req.object_id;
            nc         <= req.target_cell;
            res_status <= sgbu_pkg::STAT_SAME;
            res_found  <= 1'b0;
            res_fill   <= '0;
            // out-of-range words change nothing and report all zero
            state      <= in_range ? ST_LOOKUP : ST_FIN;
          end
        end
        ST_LOOKUP: begin
          oc       <= lc_rdata;
          nf       <= fill_rdata;
          base_old <= mul_p;
          if (lc_rdata == nc) begin
            res_fill <= fill_rdata;
            state    <= ST_FIN;
          end else begin
            state <= ST_OLD_FILL;
          end
        end
        ST_OLD_FILL: begin
          base_new <= mul_p;
          n        <= fill_clamped;
          idx      <= '0;
          state    <= (fill_clamped == '0) ? ST_INSERT : ST_SEARCH;
        end
        ST_SEARCH: begin
          if (hit) begin
            res_found <= 1'b1;
            state     <= ST_MOVE;
          end else if (idx_inc == n) begin
            // id missing from old bucket, insert anyway
            state <= ST_INSERT;
          end else begin
            idx <= idx + IdxW'(1);
          end
        end
        ST_MOVE: begin
          state <= ST_INSERT;
        end
        ST_INSERT: begin
          if (room) begin
            res_status <= sgbu_pkg::STAT_INSERT;
            res_fill   <= nf + FillW'(1);
          end else begin
            res_status <= sgbu_pkg::STAT_DROPPED;
            res_fill   <= nf;
          end
          state <= ST_FIN;
        end
        ST_FIN: begin
          if (fin_load) begin
            out_status <= res_status;
            out_found  <= res_found;
            out_fill   <= sgbu_pkg::NewFillW'(res_fill);
            state      <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out_status;
  assign rsp.found_in_old = out_found;
  assign rsp.new_fill     = out_fill;

endmodule

// ===== bench/testbench.sv =====
// self-checking bench for the spatial grid bucket updater: directed moves, then random traffic
module testbench;

  localparam int MAX_OBJ = sgbu_pkg::MAX_OBJECTS_DEF;
  localparam int CELLS   = sgbu_pkg::NUM_CELLS_DEF;
  localparam int CAP     = sgbu_pkg::CELL_CAPACITY_DEF;

  localparam logic [sgbu_pkg::StatusW-1:0] S_SAME = sgbu_pkg::STAT_SAME;
  localparam logic [sgbu_pkg::StatusW-1:0] S_INS  = sgbu_pkg::STAT_INSERT;
  localparam logic [sgbu_pkg::StatusW-1:0] S_DROP = sgbu_pkg::STAT_DROPPED;

  // longest run of cycles with no word moving on either side; covers the
  // clearing sweep after reset and the worst stall by a wide margin
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int TAIL_CYCLES    = CAP + 12;
  localparam int ITEMS_PER_PHASE = 258;
  localparam int NUM_PHASES     = 4;
  localparam int CELL_POOL      = 6;
  localparam int OBJ_POOL       = 48;
  localparam int NUM_DIRECTED   = 22;

  typedef struct packed {
    logic [sgbu_pkg::StatusW-1:0]  status;
    logic                          found;
    logic [sgbu_pkg::NewFillW-1:0] fill;
  } move_result_t;

  // one row of the directed part; typed rows carry a hand-written result
  typedef struct packed {
    logic [sgbu_pkg::ObjIdW-1:0] obj;
    logic [sgbu_pkg::CellW-1:0]  dest;
    logic                        typed;
    move_result_t                want;
  } move_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  sgbu_req_if req_ch ();
  sgbu_rsp_if rsp_ch ();

  spatial_grid_bucket_update_top i_dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  always #10 clk = ~clk;

  // mirror of the grid: recorded cell per object, fill per cell, ids per slot
  logic [sgbu_pkg::CellW-1:0]    cell_of [MAX_OBJ];
  logic [sgbu_pkg::NewFillW-1:0] fill_of [CELLS];
  logic [sgbu_pkg::ObjIdW-1:0]   slot_of [CELLS*CAP];

  move_result_t pending_moves[$];
  int error_count   = 0;
  int results_seen  = 0;
  int idle_cycles   = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  move_row_t dir_rows [NUM_DIRECTED];

  task automatic report_mismatch(input string what, input int got, input int want);
    error_count++;
    $display("mismatch at result %0d: %s got %0d expected %0d", results_seen, what, got, want);
  endtask

  // moves one object in the mirror and returns what the block should answer
  function automatic move_result_t apply_move(input logic [sgbu_pkg::ObjIdW-1:0] obj,
                                              input logic [sgbu_pkg::CellW-1:0] dest);
    move_result_t r;
    logic [sgbu_pkg::CellW-1:0] prev_cell;
    int unsigned base;
    int unsigned n;
    int unsigned nf;
    r = '{status: S_SAME, found: 1'b0, fill: '0};
    if (int'(obj) < MAX_OBJ && int'(dest) < CELLS) begin
      prev_cell = cell_of[obj];
      if (dest == prev_cell) begin
        r.fill = fill_of[dest];
      end else begin
        // search the old bucket from slot 0; first hit is replaced by the last entry
        base = int'(prev_cell) * CAP;
        n = int'(fill_of[prev_cell]);
        if (n > CAP) n = CAP;
        for (int i = 0; i < n; i++) begin
          if (!r.found && slot_of[base+i] == obj) begin
            n--;
            slot_of[base+i] = slot_of[base+n];
            fill_of[prev_cell] = sgbu_pkg::NewFillW'(n);
            r.found = 1'b1;
          end
        end
        // append to the new bucket, or drop when it is full
        nf = int'(fill_of[dest]);
        if (nf < CAP) begin
          slot_of[int'(dest)*CAP+nf] = obj;
          fill_of[dest] = sgbu_pkg::NewFillW'(nf + 1);
          r.status = S_INS;
        end else begin
          r.status = S_DROP;
        end
        cell_of[obj] = dest;
        r.fill = fill_of[dest];
      end
    end
    return r;
  endfunction

  // hands one word to the block, with an optional gap first, and records
  // the expected answer at the edge where it is taken
  task automatic issue_move(input logic [sgbu_pkg::ObjIdW-1:0] obj,
                            input logic [sgbu_pkg::CellW-1:0] dest,
                            input logic typed, input move_result_t want);
    move_result_t pred;
    if ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    req_ch.valid       <= 1'b1;
    req_ch.object_id   <= obj;
    req_ch.target_cell <= dest;
    do @(posedge clk); while (!req_ch.ready);
    pred = apply_move(obj, dest);
    pending_moves.push_back(typed ? want : pred);
  endtask

  // receiver: stall at the rate of the current phase
  always @(posedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // response checker: every accepted result against the oldest expectation
  always @(posedge clk) begin
    move_result_t exp_r;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_moves.size() == 0) begin
        report_mismatch("unexpected result, status", rsp_ch.status, -1);
      end else begin
        exp_r = pending_moves.pop_front();
        if (rsp_ch.status !== exp_r.status)
          report_mismatch("status", rsp_ch.status, exp_r.status);
        if (rsp_ch.found_in_old !== exp_r.found)
          report_mismatch("found_in_old", rsp_ch.found_in_old, exp_r.found);
        if (rsp_ch.new_fill !== exp_r.fill)
          report_mismatch("new_fill", rsp_ch.new_fill, exp_r.fill);
      end
      results_seen++;
    end
  end

  // watchdog: ends the run when nothing moves on either channel for too long
  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  initial begin
    logic [sgbu_pkg::CellW-1:0]  cell_pool [CELL_POOL];
    logic [sgbu_pkg::ObjIdW-1:0] obj_pool  [OBJ_POOL];
    logic [sgbu_pkg::ObjIdW-1:0] obj;
    logic [sgbu_pkg::CellW-1:0]  dest;

    req_ch.valid       = 1'b0;
    req_ch.object_id   = '0;
    req_ch.target_cell = '0;
    foreach (cell_of[i]) cell_of[i] = '0;
    foreach (fill_of[i]) fill_of[i] = '0;
    foreach (slot_of[i]) slot_of[i] = '0;

    // directed moves; cell 5 is filled to capacity, then ids are taken out of its middle slots
    dir_rows = '{
      '{10'd0,    12'd0,     1'b1, '{S_SAME, 1'b0, 4'd0}}, // same cell right after reset
      '{10'd1023, 12'd4095,  1'b1, '{S_INS,  1'b0, 4'd1}}, // top id to top cell, not in cell 0
      '{10'd1023, 12'd4095,  1'b1, '{S_SAME, 1'b0, 4'd1}}, // same cell reports its fill
      '{10'd1023, 12'd0,     1'b1, '{S_INS,  1'b1, 4'd1}}, // found and removed
      '{10'd0,    12'd0,     1'b1, '{S_SAME, 1'b0, 4'd1}},
      '{10'd1,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd1}},
      '{10'd2,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd2}},
      '{10'd3,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd3}},
      '{10'd4,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd4}},
      '{10'd5,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd5}},
      '{10'd6,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd6}},
      '{10'd7,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd7}},
      '{10'd8,    12'd5,     1'b1, '{S_INS,  1'b0, 4'd8}},
      '{10'd9,    12'd5,     1'b1, '{S_DROP, 1'b0, 4'd8}}, // full bucket drops the id
      '{10'd9,    12'd6,     1'b1, '{S_INS,  1'b0, 4'd1}}, // dropped id is missing from old
      '{10'd3,    12'd6,     1'b1, '{S_INS,  1'b1, 4'd2}}, // removed from a middle slot
      '{10'd8,    12'd6,     1'b1, '{S_INS,  1'b1, 4'd3}}, // last entry moved into the hole
      '{10'd1,    12'd5,     1'b1, '{S_SAME, 1'b0, 4'd6}},
      '{10'd512,  12'd2048,  1'b1, '{S_INS,  1'b0, 4'd1}},
      '{10'h155,  12'hAAA,   1'b0, '{S_SAME, 1'b0, 4'd0}},
      '{10'h2AA,  12'h555,   1'b0, '{S_SAME, 1'b0, 4'd0}},
      '{10'd1023, 12'd4095,  1'b1, '{S_INS,  1'b1, 4'd1}}  // back out of cell 0
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) begin
      issue_move(dir_rows[i].obj, dir_rows[i].dest, dir_rows[i].typed, dir_rows[i].want);
    end

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      // hold the sender until the block has answered everything
      req_ch.valid <= 1'b0;
      while (pending_moves.size() != 0) @(posedge clk);

      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 23; recv_stall_pct = 23; end
      endcase

      // a few cells and a crowd of objects, so buckets fill up, drop and drain
      foreach (cell_pool[i]) cell_pool[i] = sgbu_pkg::CellW'($urandom_range(CELLS - 1));
      foreach (obj_pool[i])  obj_pool[i]  = sgbu_pkg::ObjIdW'($urandom_range(MAX_OBJ - 1));

      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(99) < 85) begin
          obj  = obj_pool[$urandom_range(OBJ_POOL - 1)];
          dest = cell_pool[$urandom_range(CELL_POOL - 1)];
        end else begin
          // scattered noise over the whole id and cell range
          obj  = sgbu_pkg::ObjIdW'($urandom_range(MAX_OBJ - 1));
          dest = sgbu_pkg::CellW'($urandom_range(CELLS - 1));
        end
        issue_move(obj, dest, 1'b0, '0);
      end
    end

    // drain, then give the block time to show any stray result
    req_ch.valid <= 1'b0;
    while (pending_moves.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
